// File: design/gpi_pkg.sv
// ----------------------------------------------------------------------------
// gpi_pkg
// Shared widths, register codes and structs of the gravity pair interaction
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package gpi_pkg;

	// port and field widths
	localparam int POS_W     = 32;
	localparam int MASS_W    = 32;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 1;
	localparam int DV_W      = 48;

	// internal widths
	localparam int DIFF_W   = POS_W + 1;          // coordinate difference
	localparam int AD_W     = POS_W;              // magnitude of difference
	localparam int SQ_W     = 2 * AD_W;           // one squared axis
	localparam int R2_W     = SQ_W + 1;           // squared distance
	localparam int R2_PAD_W = R2_W + (R2_W % 2);  // even width for the root
	localparam int ROOT_W   = R2_PAD_W / 2;
	localparam int DP_W     = 32 + ROOT_W;        // distance partial product
	localparam int DEN_W    = R2_W + ROOT_W;      // r2 * distance
	localparam int GT_W     = 2 * CFG_W;          // gain * step
	localparam int MA_W     = MASS_W + AD_W;      // mass * difference
	localparam int NP_W     = 64;                 // 32x32 partial product
	localparam int NUM_W    = 128;                // numerator
	localparam int MAG_W    = DV_W - 1;
	localparam int Q_W      = MAG_W + 1;          // quotient bits incl. overflow bit

	localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

	// pipeline depth
	localparam int SQRT_LAT = ROOT_W;
	localparam int DIV_LAT  = Q_W;
	localparam int LATENCY  = 4 + SQRT_LAT + 3 + DIV_LAT + 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP = 1'b1;

	localparam logic [CFG_W-1:0] GAIN_RESET = 32'h0001_0000;
	localparam logic [CFG_W-1:0] STEP_RESET = 32'h0001_0000;

	// control flags that ride along with each pair
	typedef struct packed {
		logic valid;
		logic tc;
		logic negx;
		logic negy;
	} ctl_t;

	// operands kept aside while the distance is formed
	typedef struct packed {
		logic [AD_W-1:0]   adx;
		logic [AD_W-1:0]   ady;
		logic [MASS_W-1:0] m1;
		logic [MASS_W-1:0] m2;
	} car_t;

endpackage

`default_nettype wire

// File: design/gravity_pair_interaction.sv
// ----------------------------------------------------------------------------
// gravity_pair_interaction
// Fixed point 2D gravitational velocity change of a pair of bodies.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with both bodies on the input ports; the pair is taken at a
//   clock edge where start is high and busy is low. busy is low whenever
//   the block is out of reset, so one pair can be taken every cycle.
//   The velocity changes of both bodies appear once the pair has passed the
//   chain below, with done high for exactly one cycle; the four outputs,
//   too_close and saturated are valid only then.
//   Latency is set by the chain: 4 front stages (difference, magnitude,
//   squares, sum), 33 square root stages (one root bit each), 3 multiply
//   stages for denominator and numerator, 48 divider stages (one quotient
//   bit each) and the output register. Throughput is one pair per cycle.
//   gravity_gain and time_step must be written over the cfg channel while no
//   pair is in flight; the block does not enforce it. Both reset to 1.0.
//   Reset empties the pipeline; busy and cfg_ready stay high/low until the
//   first edge after reset is released. The receiver cannot stall: done
//   results are lost if not taken in their cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gravity_pair_interaction (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// command channel
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic signed [gpi_pkg::POS_W-1:0]    first_x,
	input  wire logic signed [gpi_pkg::POS_W-1:0]    first_y,
	input  wire logic        [gpi_pkg::MASS_W-1:0]   first_mass,
	input  wire logic signed [gpi_pkg::POS_W-1:0]    second_x,
	input  wire logic signed [gpi_pkg::POS_W-1:0]    second_y,
	input  wire logic        [gpi_pkg::MASS_W-1:0]   second_mass,
	// configuration channel
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic        [gpi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [gpi_pkg::CFG_W-1:0]    cfg_data,
	// results
	output logic                                     done,
	output logic signed      [gpi_pkg::DV_W-1:0]     first_dvx,
	output logic signed      [gpi_pkg::DV_W-1:0]     first_dvy,
	output logic signed      [gpi_pkg::DV_W-1:0]     second_dvx,
	output logic signed      [gpi_pkg::DV_W-1:0]     second_dvy,
	output logic                                     too_close,
	output logic                                     saturated
);
	import gpi_pkg::*;

	logic              ready_q;
	logic [CFG_W-1:0]  gain_q;
	logic [CFG_W-1:0]  step_q;
	logic [GT_W-1:0]   gt_q;

	logic              v_s1;
	logic [DIFF_W-1:0] dx_s1, dy_s1;
	logic [MASS_W-1:0] m1_s1, m2_s1;

	ctl_t              ctl_s2;
	car_t              car_s2;

	ctl_t              ctl_s3;
	car_t              car_s3;
	logic [SQ_W-1:0]   sqx_s3, sqy_s3;

	ctl_t              ctl_s4;
	car_t              car_s4;
	logic [R2_W-1:0]   r2_s4;

	ctl_t              sq_ctl [SQRT_LAT];
	car_t              sq_car [SQRT_LAT];
	logic [R2_W-1:0]   sq_r2  [SQRT_LAT];
	logic [ROOT_W-1:0] root;

	ctl_t              ctl_s6;
	logic [DP_W-1:0]   dp0_s6, dp1_s6;
	logic [ROOT_W-1:0] dp2_s6;
	logic [MA_W-1:0]   ma_s6 [4];

	ctl_t              ctl_s7;
	logic [DEN_W-1:0]  den_s7;
	logic [NP_W-1:0]   ll_s7 [4];
	logic [NP_W-1:0]   lh_s7 [4];
	logic [NP_W-1:0]   hl_s7 [4];
	logic [NP_W-1:0]   hh_s7 [4];

	ctl_t              ctl_s8;
	logic [DEN_W-1:0]  den_s8;
	logic [NUM_W-1:0]  num_s8 [4];

	ctl_t              dv_ctl [DIV_LAT];
	logic [Q_W-1:0]    q_div  [4];

	logic [3:0]        neg;
	logic [3:0]        sat_k;
	logic [DV_W-1:0]   dv_nxt [4];

	logic              done_q;
	logic [DV_W-1:0]   dv_q [4];
	logic              tc_q;
	logic              sat_q;

	// out of reset marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
		end else begin
			ready_q <= 1'b1;
		end
	end

	assign busy      = !ready_q;
	assign cfg_ready = ready_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			step_q <= STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN: gain_q <= cfg_data;
				REG_STEP: step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// G*dt; it changes only while idle if the user writes gain and step only then
	always_ff @(posedge clk) begin
		gt_q <= GT_W'(gain_q) * GT_W'(step_q);
	end

	// control path valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			for (int i = 0; i < SQRT_LAT; i++) begin
				sq_ctl[i] <= '0;
			end
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			ctl_s8 <= '0;
			for (int i = 0; i < DIV_LAT; i++) begin
				dv_ctl[i] <= '0;
			end
			done_q <= 1'b0;
		end else begin
			v_s1         <= start && !busy;
			ctl_s2.valid <= v_s1;
			ctl_s2.tc    <= (dx_s1 == '0) && (dy_s1 == '0);
			ctl_s2.negx  <= dx_s1[DIFF_W-1];
			ctl_s2.negy  <= dy_s1[DIFF_W-1];
			ctl_s3       <= ctl_s2;
			ctl_s4       <= ctl_s3;
			sq_ctl[0]    <= ctl_s4;
			for (int i = 1; i < SQRT_LAT; i++) begin
				sq_ctl[i] <= sq_ctl[i-1];
			end
			ctl_s6       <= sq_ctl[SQRT_LAT-1];
			ctl_s7       <= ctl_s6;
			ctl_s8       <= ctl_s7;
			dv_ctl[0]    <= ctl_s8;
			for (int i = 1; i < DIV_LAT; i++) begin
				dv_ctl[i] <= dv_ctl[i-1];
			end
			done_q       <= dv_ctl[DIV_LAT-1].valid;
		end
	end

	// s1: position differences
	always_ff @(posedge clk) begin
		dx_s1 <= {second_x[POS_W-1], second_x} - {first_x[POS_W-1], first_x};
		dy_s1 <= {second_y[POS_W-1], second_y} - {first_y[POS_W-1], first_y};
		m1_s1 <= first_mass;
		m2_s1 <= second_mass;
	end

	// s2: magnitudes
	always_ff @(posedge clk) begin
		car_s2.adx <= dx_s1[DIFF_W-1] ? AD_W'(-dx_s1) : dx_s1[AD_W-1:0];
		car_s2.ady <= dy_s1[DIFF_W-1] ? AD_W'(-dy_s1) : dy_s1[AD_W-1:0];
		car_s2.m1  <= m1_s1;
		car_s2.m2  <= m2_s1;
	end

	// s3: squares
	always_ff @(posedge clk) begin
		sqx_s3 <= SQ_W'(car_s2.adx) * SQ_W'(car_s2.adx);
		sqy_s3 <= SQ_W'(car_s2.ady) * SQ_W'(car_s2.ady);
		car_s3 <= car_s2;
	end

	// s4: squared distance
	always_ff @(posedge clk) begin
		r2_s4  <= R2_W'(sqx_s3) + R2_W'(sqy_s3);
		car_s4 <= car_s3;
	end

	// distance, operands wait alongside
	gpi_isqrt #(
		.IN_W (R2_PAD_W)
	) u_isqrt (
		.clk  (clk),
		.v    (R2_PAD_W'(r2_s4)),
		.root (root)
	);

	always_ff @(posedge clk) begin
		sq_car[0] <= car_s4;
		sq_r2[0]  <= r2_s4;
		for (int i = 1; i < SQRT_LAT; i++) begin
			sq_car[i] <= sq_car[i-1];
			sq_r2[i]  <= sq_r2[i-1];
		end
	end

	// s6: distance partials, mass times difference
	always_ff @(posedge clk) begin
		dp0_s6   <= DP_W'(sq_r2[SQRT_LAT-1][31:0]) * DP_W'(root);
		dp1_s6   <= DP_W'(sq_r2[SQRT_LAT-1][63:32]) * DP_W'(root);
		dp2_s6   <= sq_r2[SQRT_LAT-1][R2_W-1] ? root : '0;
		ma_s6[0] <= MA_W'(sq_car[SQRT_LAT-1].m2) * MA_W'(sq_car[SQRT_LAT-1].adx);
		ma_s6[1] <= MA_W'(sq_car[SQRT_LAT-1].m2) * MA_W'(sq_car[SQRT_LAT-1].ady);
		ma_s6[2] <= MA_W'(sq_car[SQRT_LAT-1].m1) * MA_W'(sq_car[SQRT_LAT-1].adx);
		ma_s6[3] <= MA_W'(sq_car[SQRT_LAT-1].m1) * MA_W'(sq_car[SQRT_LAT-1].ady);
	end

	// s7: denominator sum, numerator partials
	always_ff @(posedge clk) begin
		den_s7 <= DEN_W'(dp0_s6) + (DEN_W'(dp1_s6) << 32) + (DEN_W'(dp2_s6) << 64);
		for (int k = 0; k < 4; k++) begin
			ll_s7[k] <= NP_W'(gt_q[31:0])  * NP_W'(ma_s6[k][31:0]);
			lh_s7[k] <= NP_W'(gt_q[31:0])  * NP_W'(ma_s6[k][63:32]);
			hl_s7[k] <= NP_W'(gt_q[63:32]) * NP_W'(ma_s6[k][31:0]);
			hh_s7[k] <= NP_W'(gt_q[63:32]) * NP_W'(ma_s6[k][63:32]);
		end
	end

	// s8: numerators
	always_ff @(posedge clk) begin
		den_s8 <= den_s7;
		for (int k = 0; k < 4; k++) begin
			num_s8[k] <= NUM_W'(ll_s7[k]) + (NUM_W'(lh_s7[k]) << 32)
				+ (NUM_W'(hl_s7[k]) << 32) + (NUM_W'(hh_s7[k]) << 64);
		end
	end

	// one divider per velocity component
	for (genvar k = 0; k < 4; k++) begin : g_div
		gpi_div #(
			.NUM_W (NUM_W),
			.DEN_W (DEN_W),
			.Q_W   (Q_W)
		) u_div (
			.clk (clk),
			.num (num_s8[k]),
			.den (den_s8),
			.q   (q_div[k])
		);
	end

	// clamp and sign; second body points the other way
	assign neg = {!dv_ctl[DIV_LAT-1].negy, !dv_ctl[DIV_LAT-1].negx,
		dv_ctl[DIV_LAT-1].negy, dv_ctl[DIV_LAT-1].negx};

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			logic [MAG_W-1:0] mag;
			sat_k[k] = q_div[k][Q_W-1];
			mag      = sat_k[k] ? MAG_MAX : q_div[k][MAG_W-1:0];
			dv_nxt[k] = neg[k] ? (DV_W'(0) - {1'b0, mag}) : {1'b0, mag};
		end
	end

	// output register
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			dv_q[k] <= dv_ctl[DIV_LAT-1].tc ? '0 : dv_nxt[k];
		end
		tc_q  <= dv_ctl[DIV_LAT-1].tc;
		sat_q <= !dv_ctl[DIV_LAT-1].tc && (|sat_k);
	end

	assign done       = done_q;
	assign first_dvx  = dv_q[0];
	assign first_dvy  = dv_q[1];
	assign second_dvx = dv_q[2];
	assign second_dvy = dv_q[3];
	assign too_close  = tc_q;
	assign saturated  = sat_q;

endmodule

`default_nettype wire

// File: design/gpi_isqrt.sv
// ----------------------------------------------------------------------------
// gpi_isqrt
// Pipelined integer square root, one result bit per stage, floor result.
// ----------------------------------------------------------------------------
`default_nettype none

module gpi_isqrt #(
	parameter int IN_W = gpi_pkg::R2_PAD_W
) (
	input  wire logic              clk,
	input  wire logic [IN_W-1:0]   v,
	output logic      [IN_W/2-1:0] root
);
	localparam int ROOT_W = IN_W / 2;
	localparam int REM_W  = ROOT_W + 3;

	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [IN_W-1:0]   v_s    [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [IN_W-1:0]   v_in;
		logic [REM_W-1:0]  cand;
		logic [REM_W-1:0]  trial;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign v_in    = v;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign v_in    = v_s[k-1];
		end

		// bring down the next two bits, try root*4+1
		assign cand  = {rem_in[REM_W-3:0], v_in[IN_W-1 -: 2]};
		assign trial = {{(REM_W-ROOT_W-2){1'b0}}, root_in, 2'b01};

		always_ff @(posedge clk) begin
			if (cand >= trial) begin
				rem_s[k]  <= cand - trial;
				root_s[k] <= {root_in[ROOT_W-2:0], 1'b1};
			end else begin
				rem_s[k]  <= cand;
				root_s[k] <= {root_in[ROOT_W-2:0], 1'b0};
			end
			v_s[k] <= {v_in[IN_W-3:0], 2'b00};
		end
	end

	assign root = root_s[ROOT_W-1];

endmodule

`default_nettype wire

// File: design/gpi_div.sv
// ----------------------------------------------------------------------------
// gpi_div
// Pipelined restoring divider, one quotient bit per stage. The top quotient
// bit flags a quotient beyond the lower bits.
// ----------------------------------------------------------------------------
`default_nettype none

module gpi_div #(
	parameter int NUM_W = gpi_pkg::NUM_W,
	parameter int DEN_W = gpi_pkg::DEN_W,
	parameter int Q_W   = gpi_pkg::Q_W
) (
	input  wire logic             clk,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [Q_W-1:0]   q
);
	localparam int CMP_W = DEN_W + Q_W;

	logic [NUM_W-1:0] rem_s [Q_W];
	logic [DEN_W-1:0] den_s [Q_W];
	logic [Q_W-1:0]   q_s   [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		localparam int SH = Q_W - 1 - k;
		logic [NUM_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [Q_W-1:0]   q_in;
		logic [CMP_W-1:0] rem_ext;
		logic [CMP_W-1:0] dsh;
		logic [CMP_W-1:0] diff;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign q_in   = q_s[k-1];
		end

		// compare against the divisor shifted to this bit
		assign rem_ext = CMP_W'(rem_in);
		assign dsh     = CMP_W'(den_in) << SH;
		assign diff    = rem_ext - dsh;

		always_ff @(posedge clk) begin
			if (rem_ext >= dsh) begin
				rem_s[k] <= diff[NUM_W-1:0];
				q_s[k]   <= {q_in[Q_W-2:0], 1'b1};
			end else begin
				rem_s[k] <= rem_in;
				q_s[k]   <= {q_in[Q_W-2:0], 1'b0};
			end
			den_s[k] <= den_in;
		end
	end

	assign q = q_s[Q_W-1];

endmodule

`default_nettype wire

// File: design/gpi_checker.sv
// ----------------------------------------------------------------------------
// gpi_checker
// Port level checks of the pair interaction pipeline, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module gpi_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 start,
	input wire logic                                 busy,
	input wire logic                                 done,
	input wire logic signed [gpi_pkg::DV_W-1:0]      first_dvx,
	input wire logic signed [gpi_pkg::DV_W-1:0]      first_dvy,
	input wire logic signed [gpi_pkg::DV_W-1:0]      second_dvx,
	input wire logic signed [gpi_pkg::DV_W-1:0]      second_dvy,
	input wire logic                                 too_close,
	input wire logic                                 saturated
);
	import gpi_pkg::*;

	localparam logic signed [DV_W-1:0] DV_MAX = {1'b0, MAG_MAX};
	localparam logic signed [DV_W-1:0] DV_MIN = -DV_MAX;

	// every transaction yields a result after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result missing after accepted transaction");

	// no result without a transaction
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without accepted transaction");

	// coincident bodies give zero change and no clamp
	a_too_close: assert property (@(posedge clk) disable iff (!arst_n)
		(done && too_close) |-> (first_dvx == '0 && first_dvy == '0 &&
		second_dvx == '0 && second_dvy == '0 && !saturated))
		else $error("too_close result not zero");

	// a clamp shows up as a full scale component
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |-> (first_dvx == DV_MAX || first_dvx == DV_MIN ||
		first_dvy == DV_MAX || first_dvy == DV_MIN ||
		second_dvx == DV_MAX || second_dvx == DV_MIN ||
		second_dvy == DV_MAX || second_dvy == DV_MIN))
		else $error("saturated without full scale component");

endmodule

bind gravity_pair_interaction gpi_checker u_gpi_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.first_dvx  (first_dvx),
	.first_dvy  (first_dvy),
	.second_dvx (second_dvx),
	.second_dvy (second_dvy),
	.too_close  (too_close),
	.saturated  (saturated)
);

`default_nettype wire

// File: tb/gravity_pair_interaction_test.sv
// ----------------------------------------------------------------------------
// gravity_pair_interaction_test
// Self-checking bench for the pair interaction pipeline. A short directed
// table (coincident bodies, zero mass, saturation, extreme positions) is
// followed by random pairs under several gain/step settings. Each done
// transaction is compared field by field with fixed table values or a
// bit-exact model of the velocity changes, kept in order of acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

module gravity_pair_interaction_test;
	timeunit 1ns;
	timeprecision 1ps;

	import gpi_pkg::*;

	typedef struct packed {
		logic [POS_W-1:0]  x1;
		logic [POS_W-1:0]  y1;
		logic [MASS_W-1:0] m1;
		logic [POS_W-1:0]  x2;
		logic [POS_W-1:0]  y2;
		logic [MASS_W-1:0] m2;
	} pair_t;

	typedef struct packed {
		logic [DV_W-1:0] dvx1;
		logic [DV_W-1:0] dvy1;
		logic [DV_W-1:0] dvx2;
		logic [DV_W-1:0] dvy2;
		logic            tc;
		logic            sat;
	} dv_t;

	typedef struct {
		pair_t p;
		bit    fixed;
		dv_t   r;
	} row_t;

	localparam logic [DV_W-1:0] DV_POS_MAX = {1'b0, MAG_MAX};
	localparam logic [DV_W-1:0] DV_NEG_MAX = -{1'b0, MAG_MAX};
	localparam logic [POS_W-1:0] P_MIN = 32'h8000_0000;
	localparam logic [POS_W-1:0] P_MAX = 32'h7FFF_FFFF;
	localparam logic [POS_W-1:0] ONE   = 32'h0001_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [POS_W-1:0] first_x = '0, first_y = '0, second_x = '0, second_y = '0;
	logic [MASS_W-1:0] first_mass = '0, second_mass = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_GAIN;
	logic [CFG_W-1:0] cfg_data = '0;
	logic done;
	logic signed [DV_W-1:0] first_dvx, first_dvy, second_dvx, second_dvy;
	logic too_close, saturated;

	// model copy of the registers
	logic [CFG_W-1:0] gain_q = GAIN_RESET;
	logic [CFG_W-1:0] step_q = STEP_RESET;

	dv_t dv_pending[$];
	int  errors = 0;
	int  pairs_sent = 0;
	int  results_seen = 0;
	int  settings_run = 0;
	bit  no_idle = 1'b0;

	gravity_pair_interaction uut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy),
		.first_x(first_x), .first_y(first_y), .first_mass(first_mass),
		.second_x(second_x), .second_y(second_y), .second_mass(second_mass),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done),
		.first_dvx(first_dvx), .first_dvy(first_dvy),
		.second_dvx(second_dvx), .second_dvy(second_dvy),
		.too_close(too_close), .saturated(saturated)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("timeout at %0t", $time);
		$display("TB_ERROR");
		$finish;
	end

	// one axis of one body: exact quotient, clamped, then signed
	function automatic logic [DV_W-1:0] axis_dv(logic [63:0] gt, logic [MASS_W-1:0] mass,
			logic [32:0] ad, bit neg, logic [127:0] den, inout bit sat);
		logic [127:0] num, q;
		logic [MAG_W-1:0] mag;
		num = gt * mass * ad;
		q = num / den;
		if (q > {81'd0, MAG_MAX}) begin
			mag = MAG_MAX;
			sat = 1'b1;
		end else begin
			mag = q[MAG_W-1:0];
		end
		return neg ? -{1'b0, mag} : {1'b0, mag};
	endfunction

	function automatic dv_t pair_velocity(pair_t p);
		logic signed [32:0] dx, dy;
		logic [32:0] adx, ady;
		logic [65:0] r2;
		logic [33:0] root, c;
		logic [67:0] sq;
		logic [127:0] den;
		logic [63:0] gt;
		bit sat;
		dv_t r;
		r = '0;
		sat = 1'b0;
		dx = $signed(p.x2) - $signed(p.x1);
		dy = $signed(p.y2) - $signed(p.y1);
		adx = dx[32] ? -dx : dx;
		ady = dy[32] ? -dy : dy;
		if (adx == 0 && ady == 0) begin
			r.tc = 1'b1;
			return r;
		end
		r2 = adx * adx + ady * ady;
		// floor square root, one bit at a time
		root = '0;
		for (int b = 33; b >= 0; b--) begin
			c = root | (34'd1 << b);
			sq = c * c;
			if (sq <= r2)
				root = c;
		end
		den = r2 * root;
		gt = gain_q * step_q;
		r.dvx1 = axis_dv(gt, p.m2, adx, dx < 0, den, sat);
		r.dvy1 = axis_dv(gt, p.m2, ady, dy < 0, den, sat);
		r.dvx2 = axis_dv(gt, p.m1, adx, dx > 0, den, sat);
		r.dvy2 = axis_dv(gt, p.m1, ady, dy > 0, den, sat);
		r.sat = sat;
		return r;
	endfunction

	// result monitor
	always @(posedge clk) begin
		dv_t e;
		if (done) begin
			results_seen++;
			if (dv_pending.size() == 0) begin
				$display("%0t: result with nothing expected", $time);
				errors++;
			end else begin
				e = dv_pending.pop_front();
				if (first_dvx !== e.dvx1) begin
					$display("%0t: first_dvx exp %h got %h", $time, e.dvx1, first_dvx);
					errors++;
				end
				if (first_dvy !== e.dvy1) begin
					$display("%0t: first_dvy exp %h got %h", $time, e.dvy1, first_dvy);
					errors++;
				end
				if (second_dvx !== e.dvx2) begin
					$display("%0t: second_dvx exp %h got %h", $time, e.dvx2, second_dvx);
					errors++;
				end
				if (second_dvy !== e.dvy2) begin
					$display("%0t: second_dvy exp %h got %h", $time, e.dvy2, second_dvy);
					errors++;
				end
				if (too_close !== e.tc) begin
					$display("%0t: too_close exp %b got %b", $time, e.tc, too_close);
					errors++;
				end
				if (saturated !== e.sat) begin
					$display("%0t: saturated exp %b got %b", $time, e.sat, saturated);
					errors++;
				end
			end
		end
	end

	// present one pair, hold until taken, then maybe idle
	task automatic send_pair(pair_t p, dv_t e);
		first_x <= p.x1;
		first_y <= p.y1;
		first_mass <= p.m1;
		second_x <= p.x2;
		second_y <= p.y2;
		second_mass <= p.m2;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		dv_pending.push_back(e);
		pairs_sent++;
		if (!no_idle && $urandom_range(99) < 20) begin
			start <= 1'b0;
			repeat ($urandom_range(2, 1)) @(posedge clk);
		end
	endtask

	// drain the pipeline, then write one register
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		start <= 1'b0;
		while (dv_pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_GAIN)
			gain_q = val;
		else
			step_q = val;
	endtask

	function automatic logic [31:0] rand_pos(logic [31:0] base);
		case ($urandom_range(5))
			0: return $urandom();
			1: return base + $urandom_range(3) - 1;
			2: return base + ($urandom_range(255) << $urandom_range(24)) - 32'h80;
			3: return $urandom_range(1) ? P_MAX : P_MIN;
			default: return base + ($urandom() >>> $urandom_range(31));
		endcase
	endfunction

	function automatic logic [31:0] rand_mass();
		case ($urandom_range(3))
			0: return $urandom();
			1: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
			default: return $urandom() >> $urandom_range(31);
		endcase
	endfunction

	row_t table_rows[$];

	task automatic add_row(logic [31:0] x1, y1, m1, x2, y2, m2, bit fixed = 0,
			dv_t r = '0);
		row_t w;
		w.p = '{x1, y1, m1, x2, y2, m2};
		w.fixed = fixed;
		w.r = r;
		table_rows.push_back(w);
	endtask

	// stimulus
	initial begin
		pair_t p;
		logic [CFG_W-1:0] gains[7], steps[7];
		gains = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0001,
			32'h0000_0100, 32'h0, 32'h0};
		steps = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001,
			32'h0000_0400, 32'h0, 32'h0};
		gains[5] = $urandom();
		steps[5] = $urandom();
		gains[6] = $urandom_range(32'h0004_0000);
		steps[6] = $urandom_range(32'h0004_0000);

		// coincident bodies, zero mass, saturation, extreme positions
		add_row(0, 0, ONE, 0, 0, ONE, 1, '{0, 0, 0, 0, 1'b1, 1'b0});
		add_row(P_MAX, P_MIN, 32'hFFFF_FFFF, P_MAX, P_MIN, 32'hFFFF_FFFF, 1,
			'{0, 0, 0, 0, 1'b1, 1'b0});
		add_row(0, 0, 0, 1, 0, 0, 1, '{0, 0, 0, 0, 1'b0, 1'b0});
		add_row(0, 0, 32'hFFFF_FFFF, 1, 0, 32'hFFFF_FFFF, 1,
			'{DV_POS_MAX, 0, DV_NEG_MAX, 0, 1'b0, 1'b1});
		add_row(P_MIN, P_MIN, ONE, P_MAX, P_MAX, ONE);
		add_row(P_MAX, P_MAX, ONE, P_MIN, P_MIN, ONE);
		add_row(P_MIN, 0, 32'hFFFF_FFFF, P_MAX, 0, 1);
		add_row(0, P_MAX, 1, 0, P_MIN, 32'hFFFF_FFFF);
		add_row(0, 0, ONE, 32'h000A_0000, 0, ONE);
		add_row(0, 0, ONE, 0, 32'hFFF6_0000, 2 * ONE);
		add_row(32'h0003_0000, 32'h0004_0000, 5 * ONE, 0, 0, 7 * ONE);
		add_row(32'h1234_5678, 32'h8765_4321, 32'h0000_0001, 32'hFEDC_BA98, 32'h0123_4567,
			32'h0001_0000);
		add_row(32'h00C8_0000, 32'hFF38_0000, 32'h8000_0000, 32'hFF38_0000,
			32'h00C8_0000, 32'h7FFF_FFFF);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i])
			send_pair(table_rows[i].p,
				table_rows[i].fixed ? table_rows[i].r : pair_velocity(table_rows[i].p));
		settings_run++;

		for (int s = 0; s < 7; s++) begin
			write_reg(REG_GAIN, gains[s]);
			write_reg(REG_STEP, steps[s]);
			settings_run++;
			for (int n = 0; n < 120; n++) begin
				// random gain and step give nonzero results back to back
				no_idle = (s == 5);
				p.x1 = $urandom();
				p.y1 = $urandom();
				p.x2 = rand_pos(p.x1);
				p.y2 = rand_pos(p.y1);
				if ($urandom_range(29) == 0) begin
					p.x2 = p.x1;
					p.y2 = p.y1;
				end
				p.m1 = rand_mass();
				p.m2 = rand_mass();
				send_pair(p, pair_velocity(p));
			end
			no_idle = 1'b0;
		end

		start <= 1'b0;
		while (dv_pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		$display("sent %0d pairs, checked %0d results over %0d register settings",
			pairs_sent, results_seen, settings_run);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: gravity_pair_interaction.f
design/gpi_pkg.sv
design/gpi_isqrt.sv
design/gpi_div.sv
design/gravity_pair_interaction.sv
design/gpi_checker.sv
tb/gravity_pair_interaction_test.sv
